// ----- rtl/core/xtl_pkg.sv -----
// Shared types, phase codes and result encodings for the XML tag lexer.
// Used by xtl_scan, xtl_rsp_queue and xml_tag_lexer; depends on nothing.
`timescale 1ns / 1ps

package xtl_pkg;

   // Scanner limits
   localparam int unsigned MAX_NEST    = 255;
   localparam int unsigned DEPTH_W     = 9;
   localparam int unsigned MAX_RESULTS = 3;

   // Result queue geometry
   localparam int unsigned RSPQ_DEPTH = 8;
   localparam int unsigned RSPQ_AW    = $clog2(RSPQ_DEPTH);
   localparam int unsigned RSPQ_CW    = $clog2(RSPQ_DEPTH + 1);
   localparam int unsigned RSPQ_ROOM  = RSPQ_DEPTH - MAX_RESULTS;

   // Scanner phases
   typedef enum logic [4:0] {
      PH_IDLE         = 5'd0,
      PH_LT           = 5'd1,
      PH_NAME         = 5'd2,
      PH_ATTR_WS      = 5'd3,
      PH_ATTR_NAME    = 5'd4,
      PH_ATTR_EQ_WS   = 5'd5,
      PH_VAL_START    = 5'd6,
      PH_VAL_DQ       = 5'd7,
      PH_VAL_SQ       = 5'd8,
      PH_VAL_END      = 5'd9,
      PH_END_START    = 5'd10,
      PH_END_NAME     = 5'd11,
      PH_END_WS       = 5'd12,
      PH_SELF_CLOSE   = 5'd13,
      PH_SKIP         = 5'd14,
      PH_BANG         = 5'd15,
      PH_BANG_DASH    = 5'd16,
      PH_COMMENT      = 5'd17,
      PH_COMMENT_DASH = 5'd18,
      PH_COMMENT_END  = 5'd19
   } phase_type;

   // Result kinds
   localparam logic [1:0] KIND_TAG    = 2'd0;
   localparam logic [1:0] KIND_TEXT   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Tag types
   localparam logic [1:0] TAG_START = 2'd0;
   localparam logic [1:0] TAG_END   = 2'd1;
   localparam logic [1:0] TAG_SELF  = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_SYNTAX     = 2'd1;
   localparam logic [1:0] ERR_INCOMPLETE = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW   = 2'd3;

   // One result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic       tag_done;
      logic [1:0] tag_type;
      logic [1:0] error_code;
      logic       last_result;
   } rsp_entry_type;

   // Results of one scanner step, lowest entry first
   typedef struct packed {
      logic [1:0]                         count;
      rsp_entry_type [MAX_RESULTS-1:0]    entry;
   } step_type;

   function automatic rsp_entry_type tag_entry(input logic [7:0] b);
      rsp_entry_type e;
      e = '0;
      e.out_byte = b;
      e.out_kind = KIND_TAG;
      return e;
   endfunction

   function automatic rsp_entry_type text_entry(input logic [7:0] b);
      rsp_entry_type e;
      e = '0;
      e.out_byte = b;
      e.out_kind = KIND_TEXT;
      return e;
   endfunction

   function automatic rsp_entry_type close_entry(input logic [1:0] ttype);
      rsp_entry_type e;
      e = '0;
      e.out_byte = 8'h3E;
      e.out_kind = KIND_TAG;
      e.tag_done = 1'b1;
      e.tag_type = ttype;
      return e;
   endfunction

   function automatic rsp_entry_type status_entry(input logic [1:0] code);
      rsp_entry_type e;
      e = '0;
      e.out_kind   = KIND_STATUS;
      e.error_code = code;
      return e;
   endfunction

endpackage

// ----- rtl/core/xtl_scan.sv -----
// Tag scanner: phase, nesting and status registers plus the per-byte step logic.
// Produces up to three result entries per accepted byte; depends on xtl_pkg.
`timescale 1ns / 1ps

module xtl_scan (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       in_byte,
   input  logic             stream_end,
   output xtl_pkg::step_type result
);
   import xtl_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic                 end_tag_ff, end_tag_in;
   logic                 body_ff, body_in;
   logic                 failed_ff, failed_in;

   logic                 ws, n1, n2;
   logic [1:0]           ctype;
   logic [1:0]           err;
   logic [1:0]           n;
   rsp_entry_type [MAX_RESULTS-1:0] res;
   logic                 at_limit;

   // Classify the byte
   assign ws = (in_byte == 8'h20) || (in_byte > 8'd8 && in_byte < 8'd14);
   assign n1 = (in_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F});
   assign n2 = n1 || (in_byte inside {8'h2D, 8'h2E, [8'h30:8'h39]});
   assign ctype    = end_tag_ff ? TAG_END : TAG_START;
   assign at_limit = (depth_ff >= DEPTH_W'(MAX_NEST));

   // Next state and results for one byte
   always_comb begin
      phase_in   = phase_ff;
      depth_in   = depth_ff;
      end_tag_in = end_tag_ff;
      body_in    = body_ff;
      failed_in  = failed_ff;
      res        = '0;
      n          = 2'd0;
      err        = ERR_NONE;

      case (phase_ff)
         PH_IDLE: begin
            if (in_byte == 8'h3C) phase_in = PH_LT;
            else if (body_ff) begin
               res[0] = text_entry(in_byte);
               n      = 2'd1;
            end
            else if (!ws) err = ERR_SYNTAX;
         end
         PH_LT: begin
            if (in_byte == 8'h2F) begin
               phase_in   = PH_END_START;
               end_tag_in = 1'b1;
               res[0]     = tag_entry(8'h3C);
               res[1]     = tag_entry(in_byte);
               n          = 2'd2;
            end
            else if (in_byte == 8'h3F) phase_in = PH_SKIP;
            else if (in_byte == 8'h21) phase_in = PH_BANG;
            else if (n1) begin
               phase_in   = PH_NAME;
               end_tag_in = 1'b0;
               res[0]     = tag_entry(8'h3C);
               res[1]     = tag_entry(in_byte);
               n          = 2'd2;
            end
            else err = ERR_SYNTAX;
         end
         PH_NAME, PH_VAL_END: begin
            if (ws) begin
               phase_in = PH_ATTR_WS;
               res[0]   = tag_entry(8'h20);
               n        = 2'd1;
            end
            else if (in_byte == 8'h2F) begin
               phase_in = PH_SELF_CLOSE;
               res[0]   = tag_entry(8'h20);
               res[1]   = tag_entry(8'h2F);
               n        = 2'd2;
            end
            else if (in_byte == 8'h3E) begin
               phase_in = PH_IDLE;
               body_in  = 1'b1;
               res[0]   = tag_entry(8'h20);
               res[1]   = close_entry(ctype);
               n        = 2'd2;
            end
            else if (n2 && phase_ff == PH_NAME) begin
               res[0] = tag_entry(in_byte);
               n      = 2'd1;
            end
            else err = ERR_SYNTAX;
         end
         PH_ATTR_WS: begin
            if (ws) begin
            end
            else if (in_byte == 8'h2F) begin
               phase_in = PH_SELF_CLOSE;
               res[0]   = tag_entry(in_byte);
               n        = 2'd1;
            end
            else if (in_byte == 8'h3E) begin
               phase_in = PH_IDLE;
               body_in  = 1'b1;
               res[0]   = close_entry(ctype);
               n        = 2'd1;
            end
            else if (n1) begin
               phase_in = PH_ATTR_NAME;
               res[0]   = tag_entry(in_byte);
               n        = 2'd1;
            end
            else err = ERR_SYNTAX;
         end
         PH_ATTR_NAME: begin
            if (ws) phase_in = PH_ATTR_EQ_WS;
            else if (in_byte == 8'h3D) begin
               phase_in = PH_VAL_START;
               res[0]   = tag_entry(in_byte);
               n        = 2'd1;
            end
            else if (n2) begin
               res[0] = tag_entry(in_byte);
               n      = 2'd1;
            end
            else err = ERR_SYNTAX;
         end
         PH_ATTR_EQ_WS: begin
            if (ws) begin
            end
            else if (in_byte == 8'h3D) begin
               phase_in = PH_VAL_START;
               res[0]   = tag_entry(in_byte);
               n        = 2'd1;
            end
            else err = ERR_SYNTAX;
         end
         PH_VAL_START: begin
            if (ws) begin
            end
            else if (in_byte == 8'h22) begin
               phase_in = PH_VAL_DQ;
               res[0]   = tag_entry(in_byte);
               n        = 2'd1;
            end
            else if (in_byte == 8'h27) begin
               phase_in = PH_VAL_SQ;
               res[0]   = tag_entry(in_byte);
               n        = 2'd1;
            end
            else err = ERR_SYNTAX;
         end
         PH_VAL_DQ, PH_VAL_SQ: begin
            if (ws) begin
               res[0] = tag_entry(8'h20);
               n      = 2'd1;
            end
            else if (in_byte == 8'h3C) err = ERR_SYNTAX;
            else begin
               // closing quote must match the opening one
               if ((phase_ff == PH_VAL_DQ && in_byte == 8'h22) ||
                   (phase_ff == PH_VAL_SQ && in_byte == 8'h27)) phase_in = PH_VAL_END;
               res[0] = tag_entry(in_byte);
               n      = 2'd1;
            end
         end
         PH_END_START: begin
            if (n1) begin
               phase_in = PH_END_NAME;
               res[0]   = tag_entry(in_byte);
               n        = 2'd1;
            end
            else err = ERR_SYNTAX;
         end
         PH_END_NAME: begin
            if (ws) begin
               phase_in = PH_END_WS;
               res[0]   = tag_entry(8'h20);
               n        = 2'd1;
            end
            else if (in_byte == 8'h3E) begin
               phase_in = PH_IDLE;
               body_in  = 1'b1;
               res[0]   = tag_entry(8'h20);
               res[1]   = close_entry(ctype);
               n        = 2'd2;
            end
            else if (n2) begin
               res[0] = tag_entry(in_byte);
               n      = 2'd1;
            end
            else err = ERR_SYNTAX;
         end
         PH_END_WS: begin
            if (ws) begin
            end
            else if (in_byte == 8'h3E) begin
               phase_in = PH_IDLE;
               body_in  = 1'b1;
               res[0]   = close_entry(ctype);
               n        = 2'd1;
            end
            else err = ERR_SYNTAX;
         end
         PH_SELF_CLOSE: begin
            if (in_byte == 8'h3E) begin
               phase_in = PH_IDLE;
               body_in  = 1'b1;
               res[0]   = close_entry(TAG_SELF);
               n        = 2'd1;
            end
            else err = ERR_SYNTAX;
         end
         PH_SKIP: begin
            if (in_byte == 8'h3E) begin
               if (depth_ff == '0) phase_in = PH_IDLE;
            end
            else if (in_byte == 8'h5B) begin
               if (at_limit) err = ERR_OVERFLOW;
               else depth_in = depth_ff + DEPTH_W'(1);
            end
            else if (in_byte == 8'h5D) begin
               // unbalanced close bracket saturates at zero
               if (depth_ff != '0) depth_in = depth_ff - DEPTH_W'(1);
            end
         end
         PH_BANG: begin
            if (in_byte == 8'h3E) phase_in = PH_IDLE;
            else if (in_byte == 8'h2D) phase_in = PH_BANG_DASH;
            else begin
               phase_in = PH_SKIP;
               if (in_byte == 8'h5B) begin
                  if (at_limit) err = ERR_OVERFLOW;
                  else depth_in = depth_ff + DEPTH_W'(1);
               end
            end
         end
         PH_BANG_DASH: begin
            if (in_byte == 8'h3E) phase_in = PH_IDLE;
            else if (in_byte == 8'h2D) phase_in = PH_COMMENT;
            else phase_in = PH_SKIP;
         end
         PH_COMMENT: begin
            if (in_byte == 8'h2D) phase_in = PH_COMMENT_DASH;
         end
         PH_COMMENT_DASH: begin
            phase_in = (in_byte == 8'h2D) ? PH_COMMENT_END : PH_COMMENT;
         end
         PH_COMMENT_END: begin
            if (in_byte == 8'h3E) phase_in = PH_IDLE;
            else err = ERR_SYNTAX;
         end
         default: err = ERR_SYNTAX;
      endcase

      // Error replaces the step's output; incomplete end is appended
      if (err != ERR_NONE) begin
         failed_in = 1'b1;
         res       = '0;
         res[0]    = status_entry(err);
         n         = 2'd1;
      end
      else if (stream_end && (phase_in != PH_IDLE || !body_in)) begin
         failed_in = 1'b1;
         res[n]    = status_entry(ERR_INCOMPLETE);
         n         = n + 2'd1;
      end

      // Mark the last result of the step
      if (n != 2'd0) res[n - 2'd1].last_result = 1'b1;

      // Sticky failure: drop everything
      if (failed_ff) begin
         phase_in   = phase_ff;
         depth_in   = depth_ff;
         end_tag_in = end_tag_ff;
         body_in    = body_ff;
         failed_in  = failed_ff;
         n          = 2'd0;
      end
   end

   // State registers advance on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         depth_ff   <= '0;
         end_tag_ff <= 1'b0;
         body_ff    <= 1'b0;
         failed_ff  <= 1'b0;
      end
      else if (step) begin
         phase_ff   <= phase_in;
         depth_ff   <= depth_in;
         end_tag_ff <= end_tag_in;
         body_ff    <= body_in;
         failed_ff  <= failed_in;
      end
   end

   assign result.count = step ? n : 2'd0;
   assign result.entry = res;

endmodule

// ----- rtl/core/xtl_rsp_queue.sv -----
// Result queue: takes up to three entries a cycle, hands out one a cycle while ready is high.
// Register array with write and read pointers; depends on xtl_pkg.
`timescale 1ns / 1ps

module xtl_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  xtl_pkg::step_type       push,
   output logic                    room,
   output logic                    valid,
   input  logic                    ready,
   output xtl_pkg::rsp_entry_type  head
);
   import xtl_pkg::*;

   rsp_entry_type          mem [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0]     wr_ff, wr_in;
   logic [RSPQ_AW-1:0]     rd_ff, rd_in;
   logic [RSPQ_CW-1:0]     count_ff, count_in;
   logic                   pop;

   assign valid = (count_ff != '0);
   assign pop   = valid && ready;
   assign room  = (count_ff <= RSPQ_CW'(RSPQ_ROOM));
   assign head  = mem[rd_ff];

   // Pointer and fill count update
   always_comb begin
      wr_in    = wr_ff + RSPQ_AW'(push.count);
      rd_in    = rd_ff + RSPQ_AW'(pop);
      count_in = count_ff + RSPQ_CW'(push.count) - RSPQ_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end
      else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store the step's entries in order
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < push.count) mem[wr_ff + RSPQ_AW'(i)] <= push.entry[i];
      end
   end

endmodule

// ----- rtl/core/xml_tag_lexer.sv -----
// Top level of the XML tag lexer: byte stream in, normalized tag/text results out.
// Instantiates xtl_scan and xtl_rsp_queue; depends on xtl_pkg.
`timescale 1ns / 1ps
//
//  Channel   Dir  Payload
//  req_*     in   tdata[7:0] in_byte, tlast stream_end
//  rsp_*     out  tdata out_byte/tag_done/tag_type/error_code, tuser out_kind,
//                 tlast last_result
//
//  One byte is scanned per cycle while req_tready is high; its up to three
//  results enter a queue of eight entries and leave one per cycle while
//  rsp_tready is high. req_tready drops when the queue has fewer than three
//  free entries. Synchronous reset clears the scanner state and empties the
//  queue. A stall on rsp_* holds the head entry.

module xml_tag_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] tag_done, [10:9] tag_type,
                                    // [12:11] error_code, [15:13] zero
   output logic [1:0]  rsp_tuser,   // [1:0] out_kind
   output logic        rsp_tlast
);
   import xtl_pkg::*;

   step_type       step_res;
   rsp_entry_type  head;
   logic           room;
   logic           step;

   assign req_tready = room;
   assign step       = req_tvalid && room;

   xtl_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .in_byte    (req_tdata),
      .stream_end (req_tlast),
      .result     (step_res)
   );

   xtl_rsp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (step_res),
      .room  (room),
      .valid (rsp_tvalid),
      .ready (rsp_tready),
      .head  (head)
   );

   // Pack the head entry onto the stream
   assign rsp_tdata = {3'b000, head.error_code, head.tag_type, head.tag_done, head.out_byte};
   assign rsp_tuser = head.out_kind;
   assign rsp_tlast = head.last_result;

endmodule

// ----- test/tb_xml_tag_lexer.sv -----
// Self-checking testbench for xml_tag_lexer: directed and random byte streams on req_*,
// every result on rsp_* checked against a scanner predictor kept in lockstep or a typed row's expectation.
// Depends on xtl_pkg and the xml_tag_lexer RTL only.
`timescale 1ns / 1ps

module tb_xml_tag_lexer;
   import xtl_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 440;
   localparam int DRAIN_CYCLES = 32;
   localparam int HOLDOFF_AT   = 40;
   localparam int HOLDOFF_LEN  = 400;

   localparam logic [7:0] QUOTE = 8'h22;
   localparam logic [7:0] APOS  = 8'h27;

   // Scanner state as the predictor tracks it
   typedef struct packed {
      phase_type          phase;
      logic [DEPTH_W-1:0] depth;
      logic               end_tag;
      logic               body;
      logic               failed;
   } scan_state_type;

   // Next state and the results one byte produces
   typedef struct {
      scan_state_type nxt;
      int             n;
      rsp_entry_type  r[MAX_RESULTS];
   } scan_out_type;

   // One directed request; typed rows carry their expected result by hand
   typedef struct packed {
      logic [7:0]    b;
      logic          fin;
      logic          typed;
      logic [1:0]    n;
      rsp_entry_type e;
   } dir_row_type;

   localparam rsp_entry_type NO_RSP = '0;

   localparam dir_row_type DIRECTED [0:27] = '{
      // leading whitespace is dropped before the first tag
      '{" ",   1'b0, 1'b1, 2'd0, NO_RSP},
      '{8'h0D, 1'b0, 1'b1, 2'd0, NO_RSP},
      // deferred '<' then a processing span with unbalanced ']'
      '{"<",   1'b0, 1'b1, 2'd0, NO_RSP},
      '{"?",   1'b0, 1'b1, 2'd0, NO_RSP},
      '{"[",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{"]",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{"]",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{">",   1'b0, 1'b0, 2'd0, NO_RSP},
      // empty comment
      '{"<",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{"!",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{"-",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{"-",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{"-",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{"-",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{">",   1'b0, 1'b0, 2'd0, NO_RSP},
      // self-closing tag with a single-quoted value holding a tab and a quote
      '{"<",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{"Z",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{" ",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{"k",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{"=",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{APOS,  1'b0, 1'b0, 2'd0, NO_RSP},
      '{8'h09, 1'b0, 1'b0, 2'd0, NO_RSP},
      '{QUOTE, 1'b0, 1'b0, 2'd0, NO_RSP},
      '{APOS,  1'b0, 1'b0, 2'd0, NO_RSP},
      '{"/",   1'b0, 1'b0, 2'd0, NO_RSP},
      '{">",   1'b0, 1'b1, 2'd1, '{8'h3E, KIND_TAG, 1'b1, TAG_SELF, ERR_NONE, 1'b1}},
      // body text at the byte extremes, stream end in body is not an error
      '{8'hFF, 1'b1, 1'b1, 2'd1, '{8'hFF, KIND_TEXT, 1'b0, TAG_START, ERR_NONE, 1'b1}},
      '{8'h00, 1'b0, 1'b1, 2'd1, '{8'h00, KIND_TEXT, 1'b0, TAG_START, ERR_NONE, 1'b1}}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_byte
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] out_byte, [8] tag_done, [10:9] tag_type,
                             // [12:11] error_code, [15:13] zero
   logic [1:0]  rsp_tuser;   // [1:0] out_kind
   logic        rsp_tlast;

   scan_state_type scan_model;
   rsp_entry_type  tokens_due[$];
   int             mismatches = 0;
   int             cycles = 0;
   int             bytes_sent = 0;
   bit             send_idle = 1'b1;
   bit             rcv_idle = 1'b1;

   xml_tag_lexer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_entry_type make_token(input logic [7:0] b, input logic [1:0] kind,
                                                input logic done, input logic [1:0] ttype,
                                                input logic [1:0] code);
      rsp_entry_type t;
      t = '0;
      t.out_byte   = b;
      t.out_kind   = kind;
      t.tag_done   = done;
      t.tag_type   = ttype;
      t.error_code = code;
      return t;
   endfunction

   // Advance the scanner by one byte and list the results it produces
   function automatic scan_out_type next_scan(input scan_state_type s, input logic [7:0] c,
                                              input logic fin);
      scan_out_type o;
      logic         ws, n1, n2, text, close_it;
      logic [1:0]   err, ctype, close_type;
      logic [7:0]   tb[2];
      int           nt;
      o.nxt = s;
      o.n   = 0;
      for (int i = 0; i < MAX_RESULTS; i++) o.r[i] = '0;
      if (s.failed) return o;
      ws = (c == " ") || (c > 8'd8 && c < 8'd14);
      n1 = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
      n2 = n1 || c == "-" || c == "." || (c >= "0" && c <= "9");
      ctype = s.end_tag ? TAG_END : TAG_START;
      err = ERR_NONE;
      text = 1'b0;
      close_it = 1'b0;
      close_type = ctype;
      nt = 0;

      case (s.phase)
         PH_IDLE: begin
            if (c == "<") o.nxt.phase = PH_LT;
            else if (s.body) text = 1'b1;
            else if (!ws) err = ERR_SYNTAX;
         end
         PH_LT: begin
            if (c == "/") begin
               o.nxt.phase = PH_END_START; o.nxt.end_tag = 1'b1;
               tb[0] = "<"; tb[1] = c; nt = 2;
            end else if (c == "?") o.nxt.phase = PH_SKIP;
            else if (c == "!") o.nxt.phase = PH_BANG;
            else if (n1) begin
               o.nxt.phase = PH_NAME; o.nxt.end_tag = 1'b0;
               tb[0] = "<"; tb[1] = c; nt = 2;
            end else err = ERR_SYNTAX;
         end
         PH_NAME, PH_VAL_END: begin
            if (ws) begin
               o.nxt.phase = PH_ATTR_WS; tb[0] = " "; nt = 1;
            end else if (c == "/") begin
               o.nxt.phase = PH_SELF_CLOSE; tb[0] = " "; tb[1] = "/"; nt = 2;
            end else if (c == ">") begin
               tb[0] = " "; nt = 1; close_it = 1'b1;
            end else if (n2 && s.phase == PH_NAME) begin
               tb[0] = c; nt = 1;
            end else err = ERR_SYNTAX;
         end
         PH_ATTR_WS: begin
            if (ws) begin
            end else if (c == "/") begin
               o.nxt.phase = PH_SELF_CLOSE; tb[0] = c; nt = 1;
            end else if (c == ">") close_it = 1'b1;
            else if (n1) begin
               o.nxt.phase = PH_ATTR_NAME; tb[0] = c; nt = 1;
            end else err = ERR_SYNTAX;
         end
         PH_ATTR_NAME: begin
            if (ws) o.nxt.phase = PH_ATTR_EQ_WS;
            else if (c == "=") begin
               o.nxt.phase = PH_VAL_START; tb[0] = c; nt = 1;
            end else if (n2) begin
               tb[0] = c; nt = 1;
            end else err = ERR_SYNTAX;
         end
         PH_ATTR_EQ_WS: begin
            if (ws) begin
            end else if (c == "=") begin
               o.nxt.phase = PH_VAL_START; tb[0] = c; nt = 1;
            end else err = ERR_SYNTAX;
         end
         PH_VAL_START: begin
            if (ws) begin
            end else if (c == QUOTE) begin
               o.nxt.phase = PH_VAL_DQ; tb[0] = c; nt = 1;
            end else if (c == APOS) begin
               o.nxt.phase = PH_VAL_SQ; tb[0] = c; nt = 1;
            end else err = ERR_SYNTAX;
         end
         PH_VAL_DQ, PH_VAL_SQ: begin
            if (ws) begin
               tb[0] = " "; nt = 1;
            end else if (c == "<") err = ERR_SYNTAX;
            else begin
               if (c == ((s.phase == PH_VAL_DQ) ? QUOTE : APOS)) o.nxt.phase = PH_VAL_END;
               tb[0] = c; nt = 1;
            end
         end
         PH_END_START: begin
            if (n1) begin
               o.nxt.phase = PH_END_NAME; tb[0] = c; nt = 1;
            end else err = ERR_SYNTAX;
         end
         PH_END_NAME: begin
            if (ws) begin
               o.nxt.phase = PH_END_WS; tb[0] = " "; nt = 1;
            end else if (c == ">") begin
               tb[0] = " "; nt = 1; close_it = 1'b1;
            end else if (n2) begin
               tb[0] = c; nt = 1;
            end else err = ERR_SYNTAX;
         end
         PH_END_WS: begin
            if (ws) begin
            end else if (c == ">") close_it = 1'b1;
            else err = ERR_SYNTAX;
         end
         PH_SELF_CLOSE: begin
            if (c == ">") begin
               close_it = 1'b1; close_type = TAG_SELF;
            end else err = ERR_SYNTAX;
         end
         PH_SKIP: begin
            if (c == ">") begin
               if (s.depth == 0) o.nxt.phase = PH_IDLE;
            end else if (c == "[") begin
               if (s.depth >= MAX_NEST) err = ERR_OVERFLOW;
               else o.nxt.depth = s.depth + 1'b1;
            end else if (c == "]") begin
               if (s.depth > 0) o.nxt.depth = s.depth - 1'b1;
            end
         end
         PH_BANG: begin
            if (c == ">") o.nxt.phase = PH_IDLE;
            else if (c == "-") o.nxt.phase = PH_BANG_DASH;
            else begin
               o.nxt.phase = PH_SKIP;
               if (c == "[") begin
                  if (s.depth >= MAX_NEST) err = ERR_OVERFLOW;
                  else o.nxt.depth = s.depth + 1'b1;
               end
            end
         end
         PH_BANG_DASH: begin
            if (c == ">") o.nxt.phase = PH_IDLE;
            else if (c == "-") o.nxt.phase = PH_COMMENT;
            else o.nxt.phase = PH_SKIP;
         end
         PH_COMMENT: if (c == "-") o.nxt.phase = PH_COMMENT_DASH;
         PH_COMMENT_DASH: o.nxt.phase = (c == "-") ? PH_COMMENT_END : PH_COMMENT;
         PH_COMMENT_END: begin
            if (c == ">") o.nxt.phase = PH_IDLE;
            else err = ERR_SYNTAX;
         end
         default: err = ERR_SYNTAX;
      endcase

      if (err != ERR_NONE) begin
         o.nxt.failed = 1'b1;
         o.n = 1;
         o.r[0] = make_token(8'h00, KIND_STATUS, 1'b0, TAG_START, err);
      end else begin
         if (text) begin
            o.r[o.n] = make_token(c, KIND_TEXT, 1'b0, TAG_START, ERR_NONE);
            o.n++;
         end
         for (int i = 0; i < nt; i++) begin
            o.r[o.n] = make_token(tb[i], KIND_TAG, 1'b0, TAG_START, ERR_NONE);
            o.n++;
         end
         if (close_it) begin
            o.nxt.phase = PH_IDLE;
            o.nxt.body  = 1'b1;
            o.r[o.n] = make_token(8'h3E, KIND_TAG, 1'b1, close_type, ERR_NONE);
            o.n++;
         end
         // stream ends inside markup or before any tag completed
         if (fin && (o.nxt.phase != PH_IDLE || !o.nxt.body)) begin
            o.nxt.failed = 1'b1;
            o.r[o.n] = make_token(8'h00, KIND_STATUS, 1'b0, TAG_START, ERR_INCOMPLETE);
            o.n++;
         end
      end
      if (o.n > 0) o.r[o.n-1].last_result = 1'b1;
      return o;
   endfunction

   function automatic logic [7:0] ws_char();
      return ($urandom_range(0, 1) != 0) ? 8'h20 : 8'($urandom_range(9, 13));
   endfunction

   function automatic logic [7:0] name_start_char();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return "_";
   endfunction

   function automatic logic [7:0] name_char();
      case ($urandom_range(0, 9))
         6: return 8'("0" + $urandom_range(0, 9));
         7: return "-";
         8: return ".";
         default: return name_start_char();
      endcase
   endfunction

   // A byte that moves the scanner toward body text without error
   function automatic logic [7:0] closing_byte(input scan_state_type s);
      case (s.phase)
         PH_IDLE:         return s.body ? "x" : "<";
         PH_LT:           return "a";
         PH_END_START:    return "a";
         PH_ATTR_NAME:    return "=";
         PH_ATTR_EQ_WS:   return "=";
         PH_VAL_START:    return QUOTE;
         PH_VAL_DQ:       return QUOTE;
         PH_VAL_SQ:       return APOS;
         PH_SKIP:         return (s.depth != 0) ? "]" : ">";
         PH_COMMENT:      return "-";
         PH_COMMENT_DASH: return "-";
         default:         return ">";
      endcase
   endfunction

   // Mostly well-formed markup per phase, with some raw noise
   function automatic logic [7:0] markup_byte(input scan_state_type s);
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return 8'($urandom_range(0, 255));
      case (s.phase)
         PH_IDLE: begin
            if (!s.body) return (r < 60) ? "<" : ws_char();
            if (r < 40) return "<";
            if (r < 55) return ws_char();
            return 8'($urandom_range(32, 126));
         end
         PH_LT: begin
            case (r % 5)
               0: return "/";
               1: return "?";
               2: return "!";
               default: return name_start_char();
            endcase
         end
         PH_NAME, PH_END_NAME: begin
            if (r < 60) return name_char();
            if (r < 75) return ws_char();
            if (r < 85) return "/";
            return ">";
         end
         PH_ATTR_WS: begin
            if (r < 45) return name_start_char();
            if (r < 60) return ws_char();
            if (r < 72) return "/";
            return ">";
         end
         PH_ATTR_NAME: begin
            if (r < 60) return name_char();
            if (r < 75) return ws_char();
            return "=";
         end
         PH_ATTR_EQ_WS: return (r < 35) ? ws_char() : "=";
         PH_VAL_START: begin
            if (r < 25) return ws_char();
            return (r < 60) ? QUOTE : APOS;
         end
         PH_VAL_DQ, PH_VAL_SQ: begin
            if (r < 30) return (s.phase == PH_VAL_DQ) ? QUOTE : APOS;
            if (r < 45) return ws_char();
            return 8'($urandom_range(32, 126));
         end
         PH_VAL_END: begin
            if (r < 40) return ws_char();
            return (r < 55) ? "/" : ">";
         end
         PH_END_START: return name_start_char();
         PH_END_WS: return (r < 40) ? ws_char() : ">";
         PH_SKIP: begin
            if (r < 30) return "]";
            if (r < 40) return "[";
            if (r < 65) return ">";
            return 8'($urandom_range(32, 126));
         end
         PH_BANG: begin
            if (r < 45) return "-";
            if (r < 55) return "[";
            if (r < 65) return ">";
            return name_start_char();
         end
         PH_BANG_DASH: return (r < 80) ? "-" : ">";
         PH_COMMENT: return (r < 40) ? "-" : 8'($urandom_range(0, 255));
         PH_COMMENT_DASH: return (r < 60) ? "-" : 8'($urandom_range(0, 255));
         default: return ">";
      endcase
   endfunction

   // Draw a byte that keeps the scanner alive and the bracket depth shallow
   function automatic logic [7:0] live_byte(input scan_state_type s);
      logic [7:0]   c;
      scan_out_type o;
      for (int i = 0; i < 8; i++) begin
         c = markup_byte(s);
         o = next_scan(s, c, 1'b0);
         if (!o.nxt.failed && o.nxt.depth <= 4) return c;
      end
      return closing_byte(s);
   endfunction

   // Offer one request, then queue its expected results once it is taken
   task automatic offer(input logic [7:0] b, input logic fin, input logic typed,
                        input logic [1:0] n_typed, input rsp_entry_type e_typed);
      scan_out_type o;
      int           gap;
      o = next_scan(scan_model, b, fin);
      scan_model = o.nxt;
      gap = send_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      if (typed) begin
         if (n_typed != 0) tokens_due.push_back(e_typed);
      end else begin
         for (int i = 0; i < o.n; i++) tokens_due.push_back(o.r[i]);
      end
      bytes_sent++;
      if (bytes_sent % 64 == 0) send_idle = !send_idle;
   endtask

   // Compare every accepted result with the oldest expectation
   always @(posedge clock) begin
      rsp_entry_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_byte    = rsp_tdata[7:0];
         got.tag_done    = rsp_tdata[8];
         got.tag_type    = rsp_tdata[10:9];
         got.error_code  = rsp_tdata[12:11];
         got.out_kind    = rsp_tuser;
         got.last_result = rsp_tlast;
         if (tokens_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: byte %02h kind %0d done %0d type %0d err %0d last %0d",
                        got.out_byte, got.out_kind, got.tag_done, got.tag_type,
                        got.error_code, got.last_result);
         end else begin
            want = tokens_due.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected byte %02h kind %0d done %0d type %0d err %0d",
                            " last %0d, got byte %02h kind %0d done %0d type %0d err %0d",
                            " last %0d"},
                           want.out_byte, want.out_kind, want.tag_done, want.tag_type,
                           want.error_code, want.last_result, got.out_byte, got.out_kind,
                           got.tag_done, got.tag_type, got.error_code, got.last_result);
            end
         end
      end
   end

   // Result side: random stalls, one long hold-off to back up the block
   initial begin
      int stall;
      int taken;
      taken = 0;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rcv_idle ? $urandom_range(0, 7) : 0;
         if (taken == HOLDOFF_AT) stall = HOLDOFF_LEN;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
         if (taken % 64 == 0) rcv_idle = !rcv_idle;
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Request side and end of run
   initial begin
      logic [7:0]   c;
      logic         fin;
      scan_out_type trial;
      int           ending;
      int           n_random;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      scan_model = '0;
      scan_model.phase = PH_IDLE;
      // the nesting overflow ending takes the place of part of the random markup
      ending   = $urandom_range(0, 3);
      n_random = (ending == 3) ? RANDOM_ITEMS - int'(MAX_NEST) : RANDOM_ITEMS;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED[i])
         offer(DIRECTED[i].b, DIRECTED[i].fin, DIRECTED[i].typed, DIRECTED[i].n, DIRECTED[i].e);

      // random markup, stream end only where it is harmless
      for (int k = 0; k < n_random; k++) begin
         c = live_byte(scan_model);
         trial = next_scan(scan_model, c, 1'b1);
         fin = ($urandom_range(0, 15) == 0) && !trial.nxt.failed;
         offer(c, fin, 1'b0, 2'd0, NO_RSP);
      end

      // return to body text, then end cleanly or with one terminal error
      while (scan_model.phase != PH_IDLE)
         offer(closing_byte(scan_model), 1'b0, 1'b0, 2'd0, NO_RSP);
      case (ending)
         0: begin
            c = 8'($urandom_range(0, 255));
            if (c == "<") c = "x";
            offer(c, 1'b1, 1'b1, 2'd1,
                  '{c, KIND_TEXT, 1'b0, TAG_START, ERR_NONE, 1'b1});
         end
         1: begin
            offer("<", 1'b0, 1'b0, 2'd0, NO_RSP);
            do begin
               c = 8'($urandom_range(0, 255));
               trial = next_scan(scan_model, c, 1'b0);
            end while (!trial.nxt.failed);
            // syntax error wins over a stream end on the same byte
            offer(c, 1'($urandom_range(0, 1)), 1'b1, 2'd1,
                  '{8'h00, KIND_STATUS, 1'b0, TAG_START, ERR_SYNTAX, 1'b1});
         end
         2: offer("<", 1'b1, 1'b1, 2'd1,
                  '{8'h00, KIND_STATUS, 1'b0, TAG_START, ERR_INCOMPLETE, 1'b1});
         default: begin
            offer("<", 1'b0, 1'b0, 2'd0, NO_RSP);
            offer("?", 1'b0, 1'b0, 2'd0, NO_RSP);
            repeat (MAX_NEST) offer("[", 1'b0, 1'b0, 2'd0, NO_RSP);
            offer("[", 1'b0, 1'b1, 2'd1,
                  '{8'h00, KIND_STATUS, 1'b0, TAG_START, ERR_OVERFLOW, 1'b1});
         end
      endcase
      // a failed scanner stays silent
      if (ending != 0)
         repeat (6) offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'b0, 2'd0, NO_RSP);
      req_tvalid <= 1'b0;

      while (tokens_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/xtl_pkg.sv
rtl/core/xtl_scan.sv
rtl/core/xtl_rsp_queue.sv
rtl/core/xml_tag_lexer.sv
test/tb_xml_tag_lexer.sv
